>>> sv/salru_pkg.sv
// Shared constants, width helpers and sequencer state type of the LRU tag lookup.
package salru_pkg;

    localparam int ADDR_FIELD_W  = 32;
    localparam int WAY_FIELD_W   = 2;
    localparam int CNT_W         = 48;
    localparam int M_TDATA_W     = 104;

    localparam int WAYS_DEF        = 4;
    localparam int OFFSET_BITS_DEF = 4;
    localparam int INDEX_BITS_DEF  = 6;
    localparam int ADDR_BITS_DEF   = 32;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_LOOK
    } back_state_t;

    function automatic int set_width(int index_bits);
        return (index_bits > 0) ? index_bits : 1;
    endfunction

    function automatic int tag_width(int addr_bits, int offset_bits, int index_bits);
        int t;
        t = addr_bits - offset_bits - index_bits;
        return (t > 0) ? t : 1;
    endfunction

    function automatic int way_width(int ways);
        return (ways > 1) ? $clog2(ways) : 1;
    endfunction

endpackage

>>> sv/salru_front.sv
// Input side: address split into set and tag, held in a short request queue.
module salru_front import salru_pkg::*; #(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    input  logic [ADDR_FIELD_W-1:0]                         s_tdata,
    output logic                                            q_valid,
    input  logic                                            q_ready,
    output logic [set_width(INDEX_BITS)-1:0]                q_set,
    output logic [tag_width(ADDR_BITS, OFFSET_BITS, INDEX_BITS)-1:0] q_tag
);

    localparam int SET_W    = set_width(INDEX_BITS);
    localparam int TAG_W    = tag_width(ADDR_BITS, OFFSET_BITS, INDEX_BITS);
    localparam int TAG_BITS = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
    localparam int NUM_SETS = 1 << INDEX_BITS;
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW   = $clog2(QUEUE_DEPTH + 1);

    logic [ADDR_BITS-1:0] addr;
    logic [SET_W-1:0]     in_set;
    logic [TAG_W-1:0]     in_tag;

    logic [SET_W-1:0] set_q_reg [QUEUE_DEPTH];
    logic [TAG_W-1:0] tag_q_reg [QUEUE_DEPTH];

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              push, pop;

    assign addr   = s_tdata[ADDR_BITS-1:0];
    assign in_set = SET_W'(addr >> OFFSET_BITS) & SET_W'(NUM_SETS - 1);
    assign in_tag = (TAG_BITS > 0) ? TAG_W'(addr >> (OFFSET_BITS + INDEX_BITS)) : '0;

    assign s_tready = (count_reg != CNT_QW'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_set    = set_q_reg[rd_ptr_reg];
    assign q_tag    = tag_q_reg[rd_ptr_reg];

    assign push = s_tvalid && s_tready;
    assign pop  = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_QW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            set_q_reg[wr_ptr_reg] <= in_set;
            tag_q_reg[wr_ptr_reg] <= in_tag;
        end
    end

endmodule

>>> sv/salru_back.sv
// Lookup side: set row read, tag compare, LRU update, counters and result register.
module salru_back import salru_pkg::*; #(
    parameter int WAYS        = WAYS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            q_valid,
    output logic                                            q_ready,
    input  logic [set_width(INDEX_BITS)-1:0]                q_set,
    input  logic [tag_width(ADDR_BITS, OFFSET_BITS, INDEX_BITS)-1:0] q_tag,
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    output logic [M_TDATA_W-1:0]                            m_tdata,
    output logic                                            m_tuser
);

    localparam int SET_W    = set_width(INDEX_BITS);
    localparam int TAG_W    = tag_width(ADDR_BITS, OFFSET_BITS, INDEX_BITS);
    localparam int WAY_W    = way_width(WAYS);
    localparam int NUM_SETS = 1 << INDEX_BITS;
    localparam int TROW_W   = WAYS * TAG_W;
    localparam int RROW_W   = WAYS * WAY_W;
    localparam logic [WAY_W-1:0] RANK_LRU = WAY_W'(WAYS - 1);

    logic [TROW_W-1:0] tag_mem  [NUM_SETS];
    logic [RROW_W-1:0] rank_mem [NUM_SETS];
    logic [NUM_SETS-1:0][WAYS-1:0] valid_reg;

    back_state_t state_reg, state_next;

    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [TROW_W-1:0] tag_row_reg;
    logic [RROW_W-1:0] rank_row_reg;

    logic [TROW_W-1:0] tag_row_next;
    logic [RROW_W-1:0] rank_row_next;
    logic [WAYS-1:0]   row_valid, valid_row_next;

    logic [WAYS-1:0]  hit_vec;
    logic [WAY_W-1:0] hit_way, inval_way, lru_way, sel_way;
    logic [WAY_W-1:0] old_rank, rank_i;
    logic             sel_hit, row_full;

    logic mem_rd, look;

    logic [CNT_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]       miss_cnt_reg, miss_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   out_hit_reg;
    logic [WAY_FIELD_W-1:0] out_way_reg;

    assign row_valid = valid_reg[set_reg];

    always_comb begin
        hit_vec   = '0;
        hit_way   = '0;
        inval_way = '0;
        lru_way   = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (row_valid[i] && (tag_row_reg[i*TAG_W +: TAG_W] == tag_reg)) begin
                hit_vec[i] = 1'b1;
                hit_way    = WAY_W'(i);
            end
            if (!row_valid[i]) begin
                inval_way = WAY_W'(i);
            end
            if (row_valid[i] && (rank_row_reg[i*WAY_W +: WAY_W] == RANK_LRU)) begin
                lru_way = WAY_W'(i);
            end
        end
        sel_hit  = |hit_vec;
        row_full = &row_valid;
        sel_way  = sel_hit ? hit_way : (row_full ? lru_way : inval_way);
        old_rank = row_valid[sel_way] ? rank_row_reg[sel_way*WAY_W +: WAY_W] : RANK_LRU;

        rank_row_next = rank_row_reg;
        for (int i = 0; i < WAYS; i++) begin
            rank_i = rank_row_reg[i*WAY_W +: WAY_W];
            if (WAY_W'(i) == sel_way) begin
                rank_row_next[i*WAY_W +: WAY_W] = '0;
            end else if (row_valid[i] && (rank_i < old_rank)) begin
                rank_row_next[i*WAY_W +: WAY_W] = rank_i + WAY_W'(1);
            end
        end
        tag_row_next = tag_row_reg;
        tag_row_next[sel_way*TAG_W +: TAG_W] = tag_reg;
        valid_row_next = row_valid | (WAYS'(1) << sel_way);
    end

    always_comb begin
        state_next    = state_reg;
        q_ready       = 1'b0;
        look          = 1'b0;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        case (state_reg)
            BK_IDLE: begin
                q_ready = !m_valid_reg || m_tready;
                if (q_valid && q_ready) begin
                    state_next = BK_LOOK;
                end
            end
            BK_LOOK: begin
                look         = 1'b1;
                m_valid_next = 1'b1;
                state_next   = BK_IDLE;
                if (sel_hit) begin
                    if (hit_cnt_reg != '1) begin
                        hit_cnt_next = hit_cnt_reg + CNT_W'(1);
                    end
                end else if (miss_cnt_reg != '1) begin
                    miss_cnt_next = miss_cnt_reg + CNT_W'(1);
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign mem_rd = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            valid_reg    <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            m_valid_reg  <= m_valid_next;
            if (look) begin
                valid_reg[set_reg] <= valid_row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            set_reg      <= q_set;
            tag_reg      <= q_tag;
            tag_row_reg  <= tag_mem[q_set];
            rank_row_reg <= rank_mem[q_set];
        end
        if (look) begin
            tag_mem[set_reg]  <= tag_row_next;
            rank_mem[set_reg] <= rank_row_next;
            out_hit_reg       <= sel_hit;
            out_way_reg       <= WAY_FIELD_W'(sel_way);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = M_TDATA_W'({miss_cnt_reg, hit_cnt_reg, out_way_reg});

    a_look_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_LOOK) |-> $past(q_valid && q_ready))
        else $error("lookup without a popped request");

    a_out_free_on_look: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_LOOK) |-> !m_valid_reg)
        else $error("result register still full at lookup");

    a_counts_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_IDLE) |=> $stable(hit_cnt_reg) && $stable(miss_cnt_reg))
        else $error("counter moved outside a lookup");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_LOOK) |-> $onehot0(hit_vec))
        else $error("tag matched more than one valid way");

endmodule

>>> sv/set_assoc_cache_lru_lookup.sv
// Top level of the set-associative tag store with LRU replacement.
//
// One address arrives per transfer on the s_ channel (s_tdata[31:0]). It is split
// into offset, set index and tag and placed in a four-entry request queue.
// The lookup side pops one request, reads the tag and rank rows of its set,
// compares all ways and writes the updated rows back, then loads the result
// register on the m_ channel: m_tuser is the hit flag, m_tdata holds the way,
// the running hit count and the running miss count.
// An address passes the queue register, the pop and set row read in BK_IDLE through the
// registered memory read port, and the read-modify-write in BK_LOOK, then the result register;
// the lookup side takes no new address until that set row has been written back.
// Reset clears all valid bits at once and both counters; no clearing pass is
// needed and the block accepts addresses in the cycle after reset is released.
// When the receiver stalls, the result holds in the output register, the lookup
// side stops popping, and the queue keeps taking addresses until it is full.
module set_assoc_cache_lru_lookup import salru_pkg::*; #(
    parameter int WAYS        = WAYS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ADDR_FIELD_W-1:0] s_tdata,   // address[31:0]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,   // way[1:0], hit_count[49:2], miss_count[97:50]
    output logic                    m_tuser    // hit
);

    localparam int SET_W = set_width(INDEX_BITS);
    localparam int TAG_W = tag_width(ADDR_BITS, OFFSET_BITS, INDEX_BITS);

    logic             q_valid;
    logic             q_ready;
    logic [SET_W-1:0] q_set;
    logic [TAG_W-1:0] q_tag;

    salru_front #(
        .ADDR_BITS  (ADDR_BITS),
        .OFFSET_BITS(OFFSET_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_set   (q_set),
        .q_tag   (q_tag)
    );

    salru_back #(
        .WAYS       (WAYS),
        .ADDR_BITS  (ADDR_BITS),
        .OFFSET_BITS(OFFSET_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_set   (q_set),
        .q_tag   (q_tag),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

>>> dv/lru_lookup_compare.sv
// Result predictor and comparator for the LRU tag lookup stream.
module lru_lookup_compare import salru_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [ADDR_FIELD_W-1:0] s_tdata,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_W-1:0]    m_tdata,
    input  logic                    m_tuser,
    output int                      fail_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NWAYS = WAYS_DEF;
    localparam int SETS  = 1 << INDEX_BITS_DEF;
    localparam int TAG_LO = OFFSET_BITS_DEF + INDEX_BITS_DEF;
    localparam int TAG_W = ADDR_BITS_DEF - TAG_LO;
    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    typedef struct packed {
        logic                   hit;
        logic [WAY_FIELD_W-1:0] way;
        logic [CNT_W-1:0]       hits;
        logic [CNT_W-1:0]       misses;
    } lookup_result_t;

    bit               way_valid [SETS][NWAYS];
    logic [TAG_W-1:0] way_tag   [SETS][NWAYS];
    logic [1:0]       way_rank  [SETS][NWAYS];
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;

    lookup_result_t expected_results[$];

    function automatic lookup_result_t lookup_and_update(logic [ADDR_FIELD_W-1:0] addr);
        int             set_i;
        int             w;
        int             old_rank;
        bit             found;
        bit             picked;
        logic [TAG_W-1:0] tg;
        lookup_result_t r;
        set_i = addr[TAG_LO-1:OFFSET_BITS_DEF];
        tg = addr[ADDR_BITS_DEF-1:TAG_LO];
        found = 0;
        w = 0;
        for (int i = 0; i < NWAYS; i++) begin
            if (!found && way_valid[set_i][i] && way_tag[set_i][i] == tg) begin
                found = 1;
                w = i;
            end
        end
        if (found) begin
            if (hit_total != CNT_SAT) hit_total++;
        end else begin
            if (miss_total != CNT_SAT) miss_total++;
            // first empty way, else the oldest one
            picked = 0;
            for (int i = 0; i < NWAYS; i++) begin
                if (!picked && !way_valid[set_i][i]) begin
                    picked = 1;
                    w = i;
                end
            end
            if (!picked) begin
                for (int i = 0; i < NWAYS; i++) begin
                    if (way_rank[set_i][i] > way_rank[set_i][w]) w = i;
                end
            end
        end
        old_rank = way_valid[set_i][w] ? int'(way_rank[set_i][w]) : NWAYS - 1;
        for (int i = 0; i < NWAYS; i++) begin
            if (i != w && way_valid[set_i][i] && int'(way_rank[set_i][i]) < old_rank)
                way_rank[set_i][i] = way_rank[set_i][i] + 2'd1;
        end
        way_rank[set_i][w] = 2'd0;
        if (!found) begin
            way_valid[set_i][w] = 1;
            way_tag[set_i][w] = tg;
        end
        r.hit = found;
        r.way = w[WAY_FIELD_W-1:0];
        r.hits = hit_total;
        r.misses = miss_total;
        return r;
    endfunction

    task automatic report(string field, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        lookup_result_t exp_r;
        lookup_result_t act_r;
        if (!aresetn) begin
            for (int s = 0; s < SETS; s++) begin
                for (int i = 0; i < NWAYS; i++) begin
                    way_valid[s][i] = 0;
                    way_tag[s][i] = '0;
                    way_rank[s][i] = 2'd0;
                end
            end
            hit_total = '0;
            miss_total = '0;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (s_tvalid && s_tready) expected_results.push_back(lookup_and_update(s_tdata));
            if (m_tvalid && m_tready) begin
                act_r.hit = m_tuser;
                act_r.way = m_tdata[WAY_FIELD_W-1:0];
                act_r.hits = m_tdata[WAY_FIELD_W +: CNT_W];
                act_r.misses = m_tdata[WAY_FIELD_W + CNT_W +: CNT_W];
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual hit=%0b way=%0d",
                             $time, act_r.hit, act_r.way);
                end else begin
                    exp_r = expected_results.pop_front();
                    report("hit", CNT_W'(exp_r.hit), CNT_W'(act_r.hit));
                    report("way", CNT_W'(exp_r.way), CNT_W'(act_r.way));
                    report("hit_count", exp_r.hits, act_r.hits);
                    report("miss_count", exp_r.misses, act_r.misses);
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

>>> dv/tb_set_assoc_cache_lru_lookup.sv
// Stimulus, clocking and verdict for the LRU tag lookup block.
module tb_set_assoc_cache_lru_lookup import salru_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS = 1900;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [ADDR_FIELD_W-1:0] s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tuser;

    int fail_count;
    int pending;
    int cycles;
    int sent;
    bit no_gaps;
    bit rx_always_ready;
    logic [21:0] tag_base;
    int set_base;

    set_assoc_cache_lru_lookup i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lru_lookup_compare i_compare (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_addr(logic [ADDR_FIELD_W-1:0] addr, bit drain);
        int gap;
        gap = pick_gap(no_gaps);
        if (gap > 0 || drain) begin
            s_tvalid <= 1'b0;
            if (drain) begin
                wait (pending == 0);
                @(negedge aclk);
            end
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    function automatic logic [ADDR_FIELD_W-1:0] random_addr();
        int r;
        logic [21:0] tg;
        logic [5:0] st;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom;
        tg = tag_base ^ 22'($urandom_range(0, 5));
        st = (r < 75) ? 6'((set_base + $urandom_range(0, 2)) % 64) : 6'($urandom_range(0, 63));
        return {tg, st, 4'($urandom_range(0, 15))};
    endfunction

    // receiver: stall phases, random stalls, and stretches without stalls
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (rx_always_ready) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(4, 29);
                end
            end
        end
    end

    initial begin
        logic [ADDR_FIELD_W-1:0] directed [$];
        cycles = 0;
        sent = 0;
        no_gaps = 0;
        rx_always_ready = 0;
        tag_base = 22'($urandom);
        set_base = $urandom_range(0, 63);
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // extremes, hits on the same line, filling and evicting one set
        directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0005, 32'hFFFF_FFF0,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0400, 32'h0000_0800,
                     32'h0000_0C00, 32'h0000_000F, 32'h0000_1000, 32'h0000_0400,
                     32'h0000_0C08, 32'h0000_1404, 32'h0000_0000, 32'hAAAA_AAA5,
                     32'h5555_5550};
        foreach (directed[i]) send_addr(directed[i], 1'b0);

        while (sent < TOTAL_ITEMS) begin
            if (sent % 150 == 0) begin
                tag_base = 22'($urandom);
                set_base = $urandom_range(0, 63);
                no_gaps = ($urandom_range(0, 3) == 0);
                rx_always_ready = ($urandom_range(0, 3) == 0);
            end
            send_addr(random_addr(), sent == 600 || sent == 1300);
        end
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
